// ----- hw/rtl/tfsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfsd_pkg: shared types and constants for the tilt filter / shake detector
// Field widths, divider radix, register reset values and indexes, sequencer
// states, multiplier steps and payloads.
package tfsd_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_BITS         = 16;
  localparam int unsigned EXTRA_FRAC_BITS_DEF = 16;
  localparam int unsigned LEN_W               = 10;
  localparam int unsigned THR_W               = 16;
  localparam int unsigned CFG_IDX_W           = 2;
  localparam int unsigned CFG_DATA_W          = 16;
  localparam int unsigned NUM_AXES            = 3;

  // Quotient bits resolved per divider cycle
  localparam int unsigned DIV_RADIX = 4;

  // Register reset values
  localparam logic [LEN_W-1:0] FILTER_LENGTH_RST    = LEN_W'(1);
  localparam logic [LEN_W-1:0] SHAKE_AVG_LENGTH_RST = LEN_W'(30);
  localparam logic [THR_W-1:0] SHAKE_THRESHOLD_RST  = THR_W'(123);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_LENGTH    = 2'd0,
    REG_SHAKE_AVG_LENGTH = 2'd1,
    REG_SHAKE_THRESHOLD  = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SDIV_GO,
    ST_SDIV_WAIT,
    ST_ADIV_GO,
    ST_ADIV_WAIT,
    ST_MUL,
    ST_ACC,
    ST_TMUL,
    ST_CMP,
    ST_OUT
  } state_e;

  // Partial products of one squared change average
  typedef enum logic [1:0] {
    MS_LO_LO,
    MS_CROSS,
    MS_HI_HI
  } mul_step_e;

  // Payloads
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smooth_x;
    logic signed [SAMPLE_BITS-1:0] smooth_y;
    logic signed [SAMPLE_BITS-1:0] smooth_z;
    logic                          shaking;
  } out_t;

endpackage

// ----- hw/rtl/tfsd_div.sv -----
// ----------------------------------------------------------------------------
// tfsd_div: iterative signed-by-unsigned divider
// Truncates toward zero; resolves DIV_RADIX quotient bits per cycle.
// ----------------------------------------------------------------------------
module tfsd_div #(
  parameter int unsigned DIV_W = 34
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [DIV_W-1:0]        dividend_i,
  input  logic [tfsd_pkg::LEN_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic signed [DIV_W-1:0]        quotient_o
);
  import tfsd_pkg::*;

  localparam int unsigned ITER  = (DIV_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int unsigned PAD_W = ITER * DIV_RADIX;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PAD_W-1:0]  shreg_q, shreg_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  dvsr_q;
  logic [DIV_W-1:0]  mag_in;
  logic [DIV_W-1:0]  q_mag;

  // Magnitude of the incoming dividend
  assign mag_in = dividend_i[DIV_W-1] ? (~dividend_i + DIV_W'(1)) : dividend_i;

  // DIV_RADIX restoring steps on a narrow remainder
  always_comb begin
    logic [PAD_W-1:0] sh;
    logic [LEN_W:0]   r;
    sh = shreg_q;
    r  = {1'b0, rem_q};
    for (int k = 0; k < DIV_RADIX; k++) begin
      r  = {r[LEN_W-1:0], sh[PAD_W-1]};
      sh = {sh[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, dvsr_q}) begin
        r     = r - {1'b0, dvsr_q};
        sh[0] = 1'b1;
      end
    end
    shreg_d = sh;
    rem_d   = r[LEN_W-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(ITER);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q <= PAD_W'(mag_in);
      rem_q   <= '0;
      dvsr_q  <= divisor_i;
      neg_q   <= dividend_i[DIV_W-1];
    end else if (busy_q) begin
      shreg_q <= shreg_d;
      rem_q   <= rem_d;
    end
  end

  assign q_mag      = shreg_q[DIV_W-1:0];
  assign quotient_o = $signed(neg_q ? (~q_mag + DIV_W'(1)) : q_mag);
  assign done_o     = done_q;

endmodule

// ----- hw/rtl/tilt_filter_shake_detector.sv -----
// ----------------------------------------------------------------------------
// tilt_filter_shake_detector: EMA tilt smoothing with shake detection
// Accepts a new input transaction only after the previous result is loaded.
// One shared divider, resolving 4 bits/cycle, serves six divides, and one
// 17x17 multiplier forms three partial products per axis, then the threshold
// square; a compare and an output load follow.
// Reset clears filter state and output valid, and loads register defaults.
// ----------------------------------------------------------------------------
module tilt_filter_shake_detector #(
  parameter int unsigned EXTRA_FRAC_BITS = tfsd_pkg::EXTRA_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tfsd_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tfsd_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tfsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tfsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tfsd_pkg::*;

  localparam int unsigned SW    = SAMPLE_BITS + EXTRA_FRAC_BITS;  // smoothed axis
  localparam int unsigned AW    = SW + 1;                         // change average
  localparam int unsigned DW    = SW + 2;                         // divider operand
  localparam int unsigned H     = (AW + 1) / 2;                   // low half of average
  localparam int unsigned MUL_W = (H > THR_W) ? H : THR_W;
  localparam int unsigned ACC_W = 2 * AW + 2;

  // Configuration registers
  logic [LEN_W-1:0] flen_q, alen_q;
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q <= FILTER_LENGTH_RST;
      alen_q <= SHAKE_AVG_LENGTH_RST;
      thr_q  <= SHAKE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILTER_LENGTH: begin
          if (cfg_wdata_i[LEN_W-1:0] != '0) flen_q <= cfg_wdata_i[LEN_W-1:0];
        end
        REG_SHAKE_AVG_LENGTH: begin
          if (cfg_wdata_i[LEN_W-1:0] != '0) alen_q <= cfg_wdata_i[LEN_W-1:0];
        end
        REG_SHAKE_THRESHOLD: begin
          thr_q <= cfg_wdata_i[THR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_e                          state_q, state_d;
  mul_step_e                       step_q;
  logic [1:0]                      axis_q;
  logic signed [SAMPLE_BITS-1:0]   sample_q [NUM_AXES];
  logic signed [SW-1:0]            smooth_q [NUM_AXES];
  logic signed [SW-1:0]            prev_q   [NUM_AXES];
  logic [AW-1:0]                   avg_q    [NUM_AXES];
  logic [2*MUL_W-1:0]              prod_q, prod_d;
  logic [ACC_W-1:0]                acc_q, acc_add;
  logic                            shaking_q;
  logic                            out_valid_q;
  out_t                            out_q;
  logic                            out_free;

  // Divider interface
  logic                  div_start;
  logic                  div_done;
  logic signed [DW-1:0]  div_dividend;
  logic [LEN_W-1:0]      div_divisor;
  logic signed [DW-1:0]  div_quot;

  // Per-axis arithmetic
  logic signed [SW-1:0]  cur_s, cur_p, target, s_new;
  logic [AW-1:0]         cur_avg, avg_new;
  logic signed [SW:0]    diff;
  logic [SW:0]           change;
  logic signed [DW-1:0]  sdiv_operand, adiv_operand;
  logic [MUL_W-1:0]      avg_lo, avg_hi, mul_a, mul_b;

  assign cur_s   = smooth_q[axis_q];
  assign cur_p   = prev_q[axis_q];
  assign cur_avg = avg_q[axis_q];
  assign target  = {sample_q[axis_q], {EXTRA_FRAC_BITS{1'b0}}};

  // Tilt smoothing: target minus state
  assign sdiv_operand = {{2{target[SW-1]}}, target} - {{2{cur_s[SW-1]}}, cur_s};
  assign s_new        = cur_s + div_quot[SW-1:0];

  // Change average: |smooth - previous| minus average
  assign diff         = {cur_s[SW-1], cur_s} - {cur_p[SW-1], cur_p};
  assign change       = diff[SW] ? (~diff + (SW+1)'(1)) : diff;
  assign adiv_operand = {1'b0, change} - {1'b0, cur_avg};
  assign avg_new      = cur_avg + div_quot[AW-1:0];

  assign div_dividend = (state_q == ST_ADIV_GO) ? adiv_operand : sdiv_operand;
  assign div_divisor  = (state_q == ST_ADIV_GO) ? alen_q : flen_q;

  tfsd_div #(
    .DIV_W (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Shared multiplier operand select
  assign avg_lo = MUL_W'(cur_avg[H-1:0]);
  assign avg_hi = MUL_W'(cur_avg[AW-1:H]);

  always_comb begin
    mul_a = avg_lo;
    mul_b = avg_lo;
    if (state_q == ST_TMUL) begin
      mul_a = MUL_W'(thr_q);
      mul_b = MUL_W'(thr_q);
    end else begin
      unique case (step_q)
        MS_LO_LO: begin mul_a = avg_lo; mul_b = avg_lo; end
        MS_CROSS: begin mul_a = avg_hi; mul_b = avg_lo; end
        MS_HI_HI: begin mul_a = avg_hi; mul_b = avg_hi; end
        default:  begin mul_a = avg_lo; mul_b = avg_lo; end
      endcase
    end
  end

  assign prod_d = mul_a * mul_b;

  // Partial product alignment; cross term counted twice
  always_comb begin
    unique case (step_q)
      MS_LO_LO: acc_add = ACC_W'(prod_q);
      MS_CROSS: acc_add = ACC_W'(prod_q) << (H + 1);
      MS_HI_HI: acc_add = ACC_W'(prod_q) << (2 * H);
      default:  acc_add = '0;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SDIV_GO;
      ST_SDIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_SDIV_WAIT;
      end
      ST_SDIV_WAIT: if (div_done) state_d = ST_ADIV_GO;
      ST_ADIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_ADIV_WAIT;
      end
      ST_ADIV_WAIT: if (div_done) state_d = ST_MUL;
      ST_MUL:       state_d = ST_ACC;
      ST_ACC: begin
        if (step_q != MS_HI_HI) begin
          state_d = ST_MUL;
        end else if (axis_q == 2'(NUM_AXES - 1)) begin
          state_d = ST_TMUL;
        end else begin
          state_d = ST_SDIV_GO;
        end
      end
      ST_TMUL:      state_d = ST_CMP;
      ST_CMP:       state_d = ST_OUT;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Filter state, sequencing counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        smooth_q[i] <= '0;
        prev_q[i]   <= '0;
        avg_q[i]    <= '0;
      end
      axis_q      <= '0;
      step_q      <= MS_LO_LO;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_IDLE && in_valid_i) begin
        axis_q <= '0;
        step_q <= MS_LO_LO;
      end
      if (state_q == ST_SDIV_WAIT && div_done) begin
        smooth_q[axis_q] <= s_new;
      end
      if (state_q == ST_ADIV_WAIT && div_done) begin
        avg_q[axis_q]  <= avg_new;
        prev_q[axis_q] <= cur_s;
      end
      if (state_q == ST_ACC) begin
        unique case (step_q)
          MS_LO_LO: step_q <= MS_CROSS;
          MS_CROSS: step_q <= MS_HI_HI;
          MS_HI_HI: begin
            step_q <= MS_LO_LO;
            axis_q <= axis_q + 2'd1;
          end
          default:  step_q <= MS_LO_LO;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      sample_q[0] <= in_data_i.sample_x;
      sample_q[1] <= in_data_i.sample_y;
      sample_q[2] <= in_data_i.sample_z;
      acc_q       <= '0;
    end
    if (state_q == ST_MUL || state_q == ST_TMUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_q + acc_add;
    end
    if (state_q == ST_CMP) begin
      shaking_q <= acc_q > (ACC_W'(prod_q) << (2 * EXTRA_FRAC_BITS));
    end
    if (state_q == ST_OUT && out_free) begin
      out_q.smooth_x <= smooth_q[0][SW-1:EXTRA_FRAC_BITS];
      out_q.smooth_y <= smooth_q[1][SW-1:EXTRA_FRAC_BITS];
      out_q.smooth_z <= smooth_q[2][SW-1:EXTRA_FRAC_BITS];
      out_q.shaking  <= shaking_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // Only one transaction in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // Divider completes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_SDIV_WAIT || state_q == ST_ADIV_WAIT))
    else $error("divider result arrived outside a wait state");

  // Divisors never zero
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flen_q != '0 && alen_q != '0)
    else $error("zero divisor in length register");

  // A pending result holds the sequencer in the output state
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_valid_q && !out_ready_i |=> state_q == ST_OUT)
    else $error("result overwritten before it was taken");
`endif

endmodule
